### rtl/wpe_pkg.sv
// ----------------------------------------------------------------------------
// wpe_pkg
// Shared types and constants of the weather payload encoder.
// ----------------------------------------------------------------------------
package wpe_pkg;

   localparam int BYTE_W    = 8;
   localparam int MAX_BYTES = 15;
   localparam int REC_BITS  = MAX_BYTES * BYTE_W;
   localparam int COUNT_W   = 4;
   localparam int HDR_BYTES = 7;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_SEND_TEMPERATURE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEND_WIND        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SEND_HUMIDITY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SEND_PRESSURE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SEND_CHARGE      = 3'd4;

   typedef struct packed {
      logic temperature;
      logic wind;
      logic humidity;
      logic pressure;
      logic charge;
   } cfg_type;

   // one encoded payload, first byte in the low bits
   typedef struct packed {
      logic [REC_BITS-1:0] bytes;
      logic [COUNT_W-1:0]  count;
   } rec_type;

endpackage

### rtl/wpe_req_if.sv
// ----------------------------------------------------------------------------
// wpe_req_if
// Weather record channel: valid/ready handshake with the record fields.
// ----------------------------------------------------------------------------
interface wpe_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] latitude_q24;
   logic signed [32:0] longitude_q24;
   logic signed [11:0] temperature_q4;
   logic [14:0]        heading_q6;
   logic [15:0]        wind_speed_centi;
   logic [15:0]        gust_speed_centi;
   logic [9:0]         humidity_deci;
   logic [17:0]        pressure_pa;
   logic [7:0]         charge_percent;

   modport source (
      output valid, latitude_q24, longitude_q24, temperature_q4, heading_q6,
      output wind_speed_centi, gust_speed_centi, humidity_deci, pressure_pa,
      output charge_percent,
      input  ready
   );
   modport sink (
      input  valid, latitude_q24, longitude_q24, temperature_q4, heading_q6,
      input  wind_speed_centi, gust_speed_centi, humidity_deci, pressure_pa,
      input  charge_percent,
      output ready
   );
endinterface

### rtl/wpe_rsp_if.sv
// ----------------------------------------------------------------------------
// wpe_rsp_if
// Payload byte channel: valid/ready handshake with one byte and a last flag.
// ----------------------------------------------------------------------------
interface wpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;

   modport source (output valid, out_byte, last_byte, input ready);
   modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

### rtl/wpe_front.sv
// ----------------------------------------------------------------------------
// wpe_front
// Accepts a record, runs the scaling multiplies, then rounds, clamps and
// packs the enabled fields into one payload that is pushed to the queue.
// ----------------------------------------------------------------------------
module wpe_front #(
   parameter int COORD_FRAC_BITS = 24
) (
   input  logic             clock,
   input  logic             reset,
   wpe_req_if.sink          req_chan,
   input  wpe_pkg::cfg_type cfg,
   input  logic             queue_full,
   output logic             push,
   output wpe_pkg::rec_type push_rec
);
   import wpe_pkg::*;

   localparam int PROD_W = 50;
   localparam int SUM_W  = (COORD_FRAC_BITS + 24 > PROD_W) ? COORD_FRAC_BITS + 24 : PROD_W;
   localparam logic signed [17:0] LAT_SCALE  = 18'sd93206;
   localparam logic signed [16:0] LON_SCALE  = 17'sd46603;
   localparam logic [SUM_W-1:0]   ROUND_HALF = SUM_W'(1) << (COORD_FRAC_BITS - 1);

   // reciprocals: exact floor division over the input ranges used here
   localparam logic [15:0] RECIP_90  = 16'd46604;   // >> 22
   localparam logic [19:0] RECIP_5   = 20'd820;     // >> 12
   localparam logic [23:0] RECIP_25  = 24'd2622;    // >> 16
   localparam logic [35:0] RECIP_10  = 36'd209716;  // >> 21
   localparam logic [18:0] BARO_OFFSET = 19'd43000;
   localparam logic [7:0]  HUMID_MAX   = 8'd250;
   localparam logic [5:0]  CHARGE_MAX  = 6'd15;

   typedef struct packed {
      logic       fine_ok;
      logic       sat;
      logic [6:0] fine;
      logic [6:0] coarse;
   } wind_pre_type;

   // s = round(centi/20); fine is s, coarse is floor(s/5) = floor((centi+10)/100)
   function automatic wind_pre_type wind_pre(input logic [15:0] centi);
      logic [16:0]  x;
      logic [19:0]  pf;
      logic [23:0]  pc;
      wind_pre_type r;
      x         = {1'b0, centi} + 17'd10;
      pf        = x[11:2] * RECIP_5;
      pc        = x[13:2] * RECIP_25;
      r.fine_ok = (x < 17'd2560);
      r.sat     = (x >= 17'd12700);
      r.fine    = pf[18:12];
      r.coarse  = pc[22:16];
      return r;
   endfunction

   function automatic logic [7:0] wind_byte(input wind_pre_type w);
      logic [7:0] b;
      if (w.fine_ok) begin
         b = {1'b0, w.fine};
      end else begin
         b = {1'b1, (w.sat ? 7'd127 : w.coarse)};
      end
      return b;
   endfunction

   // ---------------- stage 1: multiplies ----------------
   logic                     load;
   logic                     s1_valid_ff, s1_valid_in;
   logic signed [PROD_W-1:0] lat_prod_ff, lat_prod_in;
   logic signed [PROD_W-1:0] lon_prod_ff, lon_prod_in;
   logic signed [11:0]       temp_ff;
   logic [7:0]               head_ff, head_in;
   wind_pre_type             speed_ff, speed_in, gust_ff, gust_in;
   logic [9:0]               hum_ff;
   logic                     press_neg_ff, press_neg_in;
   logic [14:0]              press_q_ff, press_q_in;
   logic [5:0]               chg_q_ff, chg_q_in;

   logic [15:0] head_sum;
   logic [31:0] head_prod;
   logic [18:0] press_diff;
   logic [17:0] press_sum;
   logic [35:0] press_prod;
   logic [9:0]  chg_sum;
   logic [17:0] chg_prod;

   assign push           = s1_valid_ff && !queue_full;
   assign req_chan.ready = !s1_valid_ff || !queue_full;
   assign load           = req_chan.valid && req_chan.ready;

   assign lat_prod_in = req_chan.latitude_q24 * LAT_SCALE;
   assign lon_prod_in = req_chan.longitude_q24 * LON_SCALE;

   assign head_sum  = {1'b0, req_chan.heading_q6} + 16'd45;
   assign head_prod = head_sum * RECIP_90;
   assign head_in   = head_prod[29:22];

   assign speed_in = wind_pre(req_chan.wind_speed_centi);
   assign gust_in  = wind_pre(req_chan.gust_speed_centi);

   assign press_diff   = {1'b0, req_chan.pressure_pa} - BARO_OFFSET;
   assign press_neg_in = press_diff[18];
   assign press_sum    = press_diff[17:0] + 18'd5;
   assign press_prod   = press_sum * RECIP_10;
   assign press_q_in   = press_prod[35:21];

   assign chg_sum  = {2'b00, req_chan.charge_percent}
                   + {1'b0, req_chan.charge_percent, 1'b0} + 10'd10;
   assign chg_prod = chg_sum[9:2] * RECIP_5[17:0];
   assign chg_q_in = chg_prod[17:12];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lat_prod_ff  <= lat_prod_in;
         lon_prod_ff  <= lon_prod_in;
         temp_ff      <= req_chan.temperature_q4;
         head_ff      <= head_in;
         speed_ff     <= speed_in;
         gust_ff      <= gust_in;
         hum_ff       <= req_chan.humidity_deci;
         press_neg_ff <= press_neg_in;
         press_q_ff   <= press_q_in;
         chg_q_ff     <= chg_q_in;
      end
   end

   // ---------------- stage 2: round, clamp, pack ----------------
   logic [SUM_W-1:0]     lat_sum, lon_sum;
   logic [23:0]          lat_enc, lon_enc;
   logic [12:0]          temp_sum;
   logic [10:0]          hum_sum;
   logic [7:0]           temp_b, hum_b, speed_b, gust_b, chg_b;
   logic [15:0]          press_v;
   logic [7:0]           flags;
   logic [REC_BITS-1:0]  acc;
   logic [COUNT_W-1:0]   count;

   // halves away from zero: add half, less one for negatives, then floor
   assign lat_sum = SUM_W'(lat_prod_ff) + ROUND_HALF - SUM_W'(lat_prod_ff[PROD_W-1]);
   assign lon_sum = SUM_W'(lon_prod_ff) + ROUND_HALF - SUM_W'(lon_prod_ff[PROD_W-1]);
   assign lat_enc = lat_sum[COORD_FRAC_BITS +: 24];
   assign lon_enc = lon_sum[COORD_FRAC_BITS +: 24];

   assign temp_sum = {temp_ff[11], temp_ff} + 13'd4 - {12'd0, temp_ff[11]};
   assign temp_b   = temp_sum[10:3];

   assign hum_sum = {1'b0, hum_ff} + 11'd2;
   assign hum_b   = (hum_sum[10:2] > {1'b0, HUMID_MAX}) ? HUMID_MAX : hum_sum[9:2];

   assign speed_b = wind_byte(speed_ff);
   assign gust_b  = wind_byte(gust_ff);

   // below the offset clamps to zero; the top of the input range stays under 65535
   assign press_v = press_neg_ff ? 16'd0 : {1'b0, press_q_ff};

   assign chg_b = {4'd0, ((chg_q_ff > CHARGE_MAX) ? CHARGE_MAX[3:0] : chg_q_ff[3:0])};

   assign flags = {1'b0, cfg.temperature, cfg.wind, cfg.humidity, cfg.pressure,
                   1'b0, cfg.charge, 1'b0};

   // prepend groups from the tail forward so enabled bytes end up packed
   always_comb begin
      acc = '0;
      if (cfg.charge) begin
         acc = {acc[REC_BITS-9:0], chg_b};
      end
      if (cfg.pressure) begin
         acc = {acc[REC_BITS-17:0], press_v[15:8], press_v[7:0]};
      end
      if (cfg.humidity) begin
         acc = {acc[REC_BITS-9:0], hum_b};
      end
      if (cfg.wind) begin
         acc = {acc[REC_BITS-25:0], gust_b, speed_b, head_ff};
      end
      if (cfg.temperature) begin
         acc = {acc[REC_BITS-9:0], temp_b};
      end
      acc = {acc[REC_BITS-57:0], lon_enc, lat_enc, flags};
   end

   assign count = COUNT_W'(HDR_BYTES)
                + COUNT_W'(cfg.temperature)
                + (cfg.wind ? COUNT_W'(3) : COUNT_W'(0))
                + COUNT_W'(cfg.humidity)
                + (cfg.pressure ? COUNT_W'(2) : COUNT_W'(0))
                + COUNT_W'(cfg.charge);

   assign push_rec.bytes = acc;
   assign push_rec.count = count;

endmodule

### rtl/wpe_queue.sv
// ----------------------------------------------------------------------------
// wpe_queue
// Short FIFO of packed payloads between the front and the byte serializer.
// ----------------------------------------------------------------------------
module wpe_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wpe_pkg::rec_type push_rec,
   input  logic             pop,
   output wpe_pkg::rec_type head,
   output logic             full,
   output logic             empty
);
   import wpe_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   rec_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

### rtl/wpe_back.sv
// ----------------------------------------------------------------------------
// wpe_back
// Serializer: takes payloads from the queue and sends them a byte per
// transfer through an output register, with no gap between payloads.
// ----------------------------------------------------------------------------
module wpe_back (
   input  logic             clock,
   input  logic             reset,
   input  wpe_pkg::rec_type head,
   input  logic             empty,
   output logic             pop,
   wpe_rsp_if.source        rsp_chan
);
   import wpe_pkg::*;

   localparam int REST_BITS = REC_BITS - BYTE_W;

   logic                 valid_ff, valid_in;
   logic                 last_ff, last_in;
   logic [BYTE_W-1:0]    byte_ff, byte_in;
   logic [REST_BITS-1:0] rest_ff, rest_in;
   logic [COUNT_W-1:0]   left_ff, left_in;

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.out_byte  = byte_ff;
   assign rsp_chan.last_byte = last_ff;

   always_comb begin
      pop      = 1'b0;
      valid_in = valid_ff;
      last_in  = last_ff;
      byte_in  = byte_ff;
      rest_in  = rest_ff;
      left_in  = left_ff;
      if (!valid_ff || rsp_chan.ready) begin
         if (left_ff != '0) begin
            // advance within the current payload
            valid_in = 1'b1;
            byte_in  = rest_ff[BYTE_W-1:0];
            last_in  = (left_ff == COUNT_W'(1));
            rest_in  = {{BYTE_W{1'b0}}, rest_ff[REST_BITS-1:BYTE_W]};
            left_in  = left_ff - COUNT_W'(1);
         end else if (!empty) begin
            // start the next payload in the same cycle
            pop      = 1'b1;
            valid_in = 1'b1;
            byte_in  = head.bytes[BYTE_W-1:0];
            last_in  = (head.count == COUNT_W'(1));
            rest_in  = head.bytes[REC_BITS-1:BYTE_W];
            left_in  = head.count - COUNT_W'(1);
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         left_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      byte_ff <= byte_in;
      rest_ff <= rest_in;
   end

endmodule

### rtl/weather_payload_encoder.sv
// ----------------------------------------------------------------------------
// weather_payload_encoder
// Takes one fixed-point weather record per transfer on req_chan and sends its
// radio payload, 7 to 15 bytes, on rsp_chan with last_byte on the final one.
// Bytes leave one per cycle while rsp_chan is ready, with no gap between
// records; a payload is 7 bytes plus 1, 3, 1, 2 and 1 for the enabled
// temperature, wind, humidity, pressure and charge groups, and the byte-wide
// result channel sets the sustained rate. The front takes a new record in
// every cycle while its two-entry queue has room. A record's first byte
// passes the stage-1 register, the queue and the output register. The APB
// send_* registers (byte addresses 0, 4, 8, 12, 16) reset to 1; the user must
// change them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module weather_payload_encoder #(
   parameter int COORD_FRAC_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   wpe_req_if.sink                            req_chan,
   wpe_rsp_if.source                          rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [wpe_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [wpe_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [wpe_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import wpe_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 rd_bit;

   logic    push, pop, full, empty;
   rec_type push_rec, head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_idx   = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_idx)
            REG_SEND_TEMPERATURE: cfg_in.temperature = pwdata[0];
            REG_SEND_WIND:        cfg_in.wind        = pwdata[0];
            REG_SEND_HUMIDITY:    cfg_in.humidity    = pwdata[0];
            REG_SEND_PRESSURE:    cfg_in.pressure    = pwdata[0];
            REG_SEND_CHARGE:      cfg_in.charge      = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SEND_TEMPERATURE: rd_bit = cfg_ff.temperature;
         REG_SEND_WIND:        rd_bit = cfg_ff.wind;
         REG_SEND_HUMIDITY:    rd_bit = cfg_ff.humidity;
         REG_SEND_PRESSURE:    rd_bit = cfg_ff.pressure;
         REG_SEND_CHARGE:      rd_bit = cfg_ff.charge;
         default:              rd_bit = 1'b0;
      endcase
   end

   assign prdata = {{(CSR_DATA_W-1){1'b0}}, rd_bit};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wpe_front #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .queue_full (full),
      .push       (push),
      .push_rec   (push_rec)
   );

   wpe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head     (head),
      .full     (full),
      .empty    (empty)
   );

   wpe_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .empty    (empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### rtl/wpe_checker.sv
// ----------------------------------------------------------------------------
// wpe_checker
// Port-level checks of the weather payload encoder, bound to the top level.
// ----------------------------------------------------------------------------
module wpe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_byte
);
   logic       req_xfer, rsp_xfer;
   logic [3:0] byte_cnt_ff, byte_cnt_in;
   logic [2:0] pending_ff, pending_in;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      byte_cnt_in = byte_cnt_ff;
      if (rsp_xfer) begin
         byte_cnt_in = rsp_last_byte ? 4'd0 : byte_cnt_ff + 4'd1;
      end
      pending_in = pending_ff + 3'(req_xfer) - 3'(rsp_xfer && rsp_last_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff <= '0;
         pending_ff  <= '0;
      end else begin
         byte_cnt_ff <= byte_cnt_in;
         pending_ff  <= pending_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                   && $stable(rsp_last_byte))
      else $error("stalled result changed");

   a_flags_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && byte_cnt_ff == 4'd0 |->
         rsp_out_byte[7] == 1'b0 && rsp_out_byte[2] == 1'b0 && rsp_out_byte[0] == 1'b0)
      else $error("flags byte has reserved bits set");

   a_length: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> (rsp_last_byte ? byte_cnt_ff >= 4'd6 : byte_cnt_ff < 4'd14))
      else $error("payload length outside 7 to 15 bytes");

   a_pending: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd4 && (!rsp_xfer || pending_ff != 3'd0))
      else $error("result without record or too many records in flight");

endmodule

bind weather_payload_encoder wpe_checker u_wpe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_byte  (rsp_chan.out_byte),
   .rsp_last_byte (rsp_chan.last_byte)
);
